// ===== hdl/bpf_pkg.sv =====
// Shared constants, command codes and types for the BMP pixel fetch block.
// Used by bmp_pixel_fetch and bpf_seq under hdl, and by the bench; depends on nothing.
package bpf_pkg;

  localparam int IMAGE_BYTES   = 65536;
  localparam int IMG_AW        = $clog2(IMAGE_BYTES);
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_DW        = 24;

  localparam int ALU_W = 29;

  localparam logic [1:0] CMD_LOAD_IMAGE   = 2'd0;
  localparam logic [1:0] CMD_LOAD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_READ_PIXEL   = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_BITS_PER_PIXEL = 2'd2;
  localparam logic [1:0] CFG_COLORS_USED    = 2'd3;

  typedef struct packed {
    logic [12:0]        image_width;
    logic signed [13:0] image_height;
    logic [5:0]         bits_per_pixel;
    logic [8:0]         colors_used;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       address_error;
  } res_t;

endpackage

// ===== hdl/bmp_pixel_fetch.sv =====
// Top level of the BMP pixel fetch: configuration registers, image and palette
// stores, and the read sequencer. Uses bpf_pkg, bpf_ram and bpf_seq.
//
//   Channel   Handshake                  Payload
//   input     start / busy               in_cmd, in_load_address, in_load_data,
//                                        in_pixel_row, in_pixel_col
//   result    out_valid (one cycle)      out_red, out_green, out_blue, out_address_error
//   config    cfg_we                     cfg_index, cfg_wdata
//
// A load is written in the cycle it is accepted and leaves busy low.
// A read at 24 or 32 bits per pixel is paced by three byte reads from
// the one image memory port; at 1 to 8 bits it is paced by the 8-step modulo.
// The result strobe is high in the first cycle with busy low, and a new item may be
// taken in that same cycle.
// Reset clears control state only; both stores hold garbage until written.
module bmp_pixel_fetch
  import bpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_load_address,
  input  logic [23:0] in_load_data,
  input  logic [11:0] in_pixel_row,
  input  logic [11:0] in_pixel_col,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_address_error,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  cfg_t              cfg_r;
  res_t              res;
  logic              accept;
  logic              img_we;
  logic              pal_we;
  logic              rd_go;
  logic [IMG_AW-1:0] img_raddr;
  logic [7:0]        img_rdata;
  logic [PAL_AW-1:0] pal_raddr;
  logic [PAL_DW-1:0] pal_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 13'd1;
      cfg_r.image_height   <= 14'sd1;
      cfg_r.bits_per_pixel <= 6'd8;
      cfg_r.colors_used    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_wdata[12:0];
        CFG_IMAGE_HEIGHT:   cfg_r.image_height   <= $signed(cfg_wdata);
        CFG_BITS_PER_PIXEL: cfg_r.bits_per_pixel <= cfg_wdata[5:0];
        CFG_COLORS_USED:    cfg_r.colors_used    <= cfg_wdata[8:0];
      endcase
    end
  end

  assign accept = start && !busy;
  assign img_we = accept && (in_cmd == CMD_LOAD_IMAGE) &&
                  (32'(in_load_address) < IMAGE_BYTES);
  assign pal_we = accept && (in_cmd == CMD_LOAD_PALETTE) &&
                  (32'(in_load_address) < PALETTE_DEPTH);
  assign rd_go  = accept && (in_cmd == CMD_READ_PIXEL);

  bpf_ram #(
    .AW (IMG_AW),
    .DW (8)
  ) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (in_load_address[IMG_AW-1:0]),
    .wdata (in_load_data[7:0]),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  bpf_ram #(
    .AW (PAL_AW),
    .DW (PAL_DW)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_load_address[PAL_AW-1:0]),
    .wdata (in_load_data),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  bpf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (rd_go),
    .pixel_row (in_pixel_row),
    .pixel_col (in_pixel_col),
    .cfg       (cfg_r),
    .busy      (busy),
    .img_raddr (img_raddr),
    .img_rdata (img_rdata),
    .pal_raddr (pal_raddr),
    .pal_rdata (pal_rdata),
    .res       (res)
  );

  assign out_valid         = res.valid;
  assign out_red           = res.red;
  assign out_green         = res.green;
  assign out_blue          = res.blue;
  assign out_address_error = res.address_error;

`ifndef SYNTHESIS
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a read is in progress");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd != CMD_READ_PIXEL)) |=> !busy)
    else $error("load or unused command made the block busy");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_READ_PIXEL)) |=> busy)
    else $error("accepted read did not start the sequencer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

// ===== hdl/bpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bpf_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bpf_seq.sv =====
// Read sequencer for the pixel fetch: one multiplier, one shared adder/subtractor
// and a small state machine that drives the image and palette reads. Uses bpf_pkg.
module bpf_seq
  import bpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [11:0]       pixel_row,
  input  logic [11:0]       pixel_col,
  input  cfg_t              cfg,
  output logic              busy,
  output logic [IMG_AW-1:0] img_raddr,
  input  logic [7:0]        img_rdata,
  output logic [PAL_AW-1:0] pal_raddr,
  input  logic [PAL_DW-1:0] pal_rdata,
  output res_t              res
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BASE = 4'd1;
  localparam logic [3:0] ST_ADDR = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_IDX  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_PAL  = 4'd6;
  localparam logic [3:0] ST_PALD = 4'd7;
  localparam logic [3:0] ST_RD1  = 4'd8;
  localparam logic [3:0] ST_RD2  = 4'd9;
  localparam logic [3:0] ST_RD3  = 4'd10;

  logic [3:0]        state_r;
  logic signed [14:0] srow_r;
  logic              bad_r;
  logic [11:0]       col_r;
  logic [15:0]       stride_r;
  logic [ALU_W-1:0]  base_r;
  logic [ALU_W-1:0]  addr_r;
  logic [7:0]        idx_r;
  logic [8:0]        rem_r;
  logic [8:0]        ncol_r;
  logic [2:0]        step_r;
  logic [7:0]        blue_r;
  logic [7:0]        green_r;
  res_t              res_r;

  logic [5:0]        bpp;
  logic              bpp_ok;
  logic              pal_mode;
  logic [17:0]       row_bits;
  logic [18:0]       row_bits_pad;
  logic [15:0]       stride;
  logic signed [14:0] srow;
  logic [13:0]       offset;
  logic [2:0]        shamt;
  logic [7:0]        mask;
  logic [7:0]        idx;
  logic [9:0]        div_t;
  logic [ALU_W-1:0]  opa;
  logic [ALU_W-1:0]  opb;
  logic              cin;
  logic [ALU_W:0]    sum;

  assign bpp      = cfg.bits_per_pixel;
  assign bpp_ok   = (bpp == 6'd1) || (bpp == 6'd2) || (bpp == 6'd4) || (bpp == 6'd8) ||
                    (bpp == 6'd24) || (bpp == 6'd32);
  assign pal_mode = (bpp <= 6'd8);

  always_comb begin
    case (bpp)
      6'd1:    row_bits = {5'd0, cfg.image_width};
      6'd2:    row_bits = {4'd0, cfg.image_width, 1'b0};
      6'd4:    row_bits = {3'd0, cfg.image_width, 2'b0};
      6'd8:    row_bits = {2'd0, cfg.image_width, 3'b0};
      6'd24:   row_bits = {1'b0, cfg.image_width, 4'b0} + {2'd0, cfg.image_width, 3'b0};
      6'd32:   row_bits = {cfg.image_width, 5'b0};
      default: row_bits = '0;
    endcase
  end

  assign row_bits_pad = {1'b0, row_bits} + 19'd31;
  assign stride       = {row_bits_pad[18:5], 2'b00};

  assign srow = (cfg.image_height > 14'sd0)
              ? ({cfg.image_height[13], cfg.image_height} - 15'sd1 - $signed({3'b000, pixel_row}))
              : $signed({3'b000, pixel_row});

  always_comb begin
    case (bpp)
      6'd1:    offset = {5'd0, col_r[11:3]};
      6'd2:    offset = {4'd0, col_r[11:2]};
      6'd4:    offset = {3'd0, col_r[11:1]};
      6'd8:    offset = {2'd0, col_r};
      6'd24:   offset = {1'b0, col_r, 1'b0} + {2'd0, col_r};
      6'd32:   offset = {col_r, 2'b00};
      default: offset = '0;
    endcase
  end

  always_comb begin
    case (bpp)
      6'd1:    shamt = ~col_r[2:0];
      6'd2:    shamt = {~col_r[1:0], 1'b0};
      6'd4:    shamt = {~col_r[0], 2'b00};
      default: shamt = 3'd0;
    endcase
  end

  assign mask  = 8'((9'd1 << bpp[3:0]) - 9'd1);
  assign idx   = (img_rdata >> shamt) & mask;
  assign div_t = {rem_r, idx_r[7]};

  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    case (state_r)
      ST_ADDR: begin
        opa = base_r;
        opb = ALU_W'(offset);
      end
      ST_CHK, ST_RD1: begin
        opa = addr_r;
        opb = ALU_W'(1);
      end
      ST_DIV: begin
        opa = ALU_W'(div_t);
        opb = ~ALU_W'(ncol_r);
        cin = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign sum = {1'b0, opa} + {1'b0, opb} + (ALU_W + 1)'(cin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          res_r.valid <= 1'b0;
          if (go) begin
            srow_r   <= srow;
            bad_r    <= !bpp_ok;
            col_r    <= pixel_col;
            stride_r <= stride;
            state_r  <= ST_BASE;
          end
        end
        ST_BASE: begin
          base_r <= ALU_W'(srow_r[12:0]) * ALU_W'(stride_r);
          if (bad_r || srow_r[14]) begin
            res_r   <= '{valid: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0, address_error: 1'b1};
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          addr_r  <= sum[ALU_W-1:0];
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (pal_mode) begin
            if (addr_r >= ALU_W'(IMAGE_BYTES)) begin
              res_r   <= '{valid: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0,
                           address_error: 1'b1};
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_IDX;
            end
          end else begin
            if (addr_r >= ALU_W'(IMAGE_BYTES - 2)) begin
              res_r   <= '{valid: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0,
                           address_error: 1'b1};
              state_r <= ST_IDLE;
            end else begin
              addr_r  <= sum[ALU_W-1:0];
              state_r <= ST_RD1;
            end
          end
        end
        ST_IDX: begin
          idx_r   <= idx;
          rem_r   <= '0;
          step_r  <= '0;
          ncol_r  <= (cfg.colors_used == 9'd0) ? (9'd1 << bpp[3:0]) : cfg.colors_used;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= sum[ALU_W] ? sum[8:0] : div_t[8:0];
          idx_r  <= {idx_r[6:0], 1'b0};
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= ST_PAL;
          end
        end
        ST_PAL: begin
          if (rem_r >= 9'(PALETTE_DEPTH)) begin
            res_r   <= '{valid: 1'b1, red: 8'd0, green: 8'd0, blue: 8'd0, address_error: 1'b1};
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_PALD;
          end
        end
        ST_PALD: begin
          res_r   <= '{valid: 1'b1, red: pal_rdata[23:16], green: pal_rdata[15:8],
                       blue: pal_rdata[7:0], address_error: 1'b0};
          state_r <= ST_IDLE;
        end
        ST_RD1: begin
          blue_r  <= img_rdata;
          addr_r  <= sum[ALU_W-1:0];
          state_r <= ST_RD2;
        end
        ST_RD2: begin
          green_r <= img_rdata;
          state_r <= ST_RD3;
        end
        ST_RD3: begin
          res_r   <= '{valid: 1'b1, red: img_rdata, green: green_r, blue: blue_r,
                       address_error: 1'b0};
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign img_raddr = addr_r[IMG_AW-1:0];
  assign pal_raddr = rem_r[PAL_AW-1:0];
  assign res       = res_r;

endmodule

// ===== bench/bmp_pixel_fetch_tb.sv =====
// Self-checking bench for bmp_pixel_fetch: image and palette loads, pixel reads and
// register writes, with every read checked against a pixel fetch model held in the bench or a fixed expected value.
// Depends on bpf_pkg and the RTL under hdl.
module bmp_pixel_fetch_tb import bpf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         PHASES       = 16;
  localparam int         PHASE_ITEMS  = 45;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       address_error;
  } pixel_t;

  localparam pixel_t PIXEL_FAULT = '{8'h00, 8'h00, 8'h00, 1'b1};

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [23:0] data;
    logic [11:0] row;
    logic [11:0] col;
    cfg_t        regs;
    logic        fixed;
    pixel_t      want;
  } dir_step_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [15:0] in_load_address;
  logic [23:0] in_load_data;
  logic [11:0] in_pixel_row;
  logic [11:0] in_pixel_col;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_address_error;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_wdata;

  logic [7:0]  image_bytes [IMAGE_BYTES];
  bit          image_known [IMAGE_BYTES];
  logic [23:0] palette_words [PALETTE_DEPTH];
  bit          palette_known [PALETTE_DEPTH];
  cfg_t        live_cfg;
  pixel_t      expected_pixels [$];
  dir_step_t   dir_steps [$];
  int unsigned fail_count;
  int          idle_pct;

  bmp_pixel_fetch i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_load_address   (in_load_address),
    .in_load_data      (in_load_data),
    .in_pixel_row      (in_pixel_row),
    .in_pixel_col      (in_pixel_col),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_address_error (out_address_error),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A read touches n bytes from address a; n stays 0 when it fails before using the store.
  function automatic void pixel_span(input logic [11:0] row, input logic [11:0] col,
                                     output longint a, output int n);
    longint h, srow, stride, bpp, r, c;
    bpp = live_cfg.bits_per_pixel;
    h = live_cfg.image_height;
    r = row;
    c = col;
    srow = (h > 0) ? h - r - 1 : r;
    a = 0;
    n = 0;
    if (!(bpp inside {1, 2, 4, 8, 24, 32}) || srow < 0) return;
    stride = ((longint'(live_cfg.image_width) * bpp + 31) >> 5) << 2;
    if (bpp <= 8) begin
      a = srow * stride + c / (8 / bpp);
      if (a < IMAGE_BYTES) n = 1;
    end else begin
      a = srow * stride + (bpp / 8) * c;
      if (a + 2 < IMAGE_BYTES) n = 3;
    end
  endfunction

  function automatic int palette_slot(input logic [11:0] row, input logic [11:0] col);
    longint a, per, bpp, idx, ncol, c;
    int n;
    pixel_span(row, col, a, n);
    if (n != 1) return -1;
    bpp = live_cfg.bits_per_pixel;
    c = col;
    per = 8 / bpp;
    idx = (longint'(image_bytes[a]) >> ((per - 1 - c % per) * bpp)) & ((64'd1 << bpp) - 1);
    ncol = (live_cfg.colors_used == 0) ? (64'd1 << bpp) : longint'(live_cfg.colors_used);
    return int'(idx % ncol);
  endfunction

  function automatic pixel_t predict_pixel(input logic [11:0] row, input logic [11:0] col);
    longint a;
    int n, slot;
    logic [23:0] w;
    pixel_span(row, col, a, n);
    if (n == 3) return '{image_bytes[a + 2], image_bytes[a + 1], image_bytes[a], 1'b0};
    slot = palette_slot(row, col);
    if (n == 0 || slot >= PALETTE_DEPTH) return PIXEL_FAULT;
    w = palette_words[slot];
    return '{w[23:16], w[15:8], w[7:0], 1'b0};
  endfunction

  function automatic dir_step_t item_step(input logic [1:0] cmd, input logic [15:0] addr,
                                          input logic [23:0] data, input logic [11:0] row,
                                          input logic [11:0] col, input bit fixed = 1'b0,
                                          input pixel_t want = '0);
    dir_step_t s;
    s = '0;
    s.cmd = cmd;
    s.addr = addr;
    s.data = data;
    s.row = row;
    s.col = col;
    s.fixed = fixed;
    s.want = want;
    return s;
  endfunction

  function automatic dir_step_t cfg_step(input logic [12:0] w, input logic signed [13:0] h,
                                         input logic [5:0] b, input logic [8:0] c);
    dir_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.regs = cfg_t'{w, h, b, c};
    return s;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [23:0] data, input logic [11:0] row,
                           input logic [11:0] col, input bit fixed = 1'b0,
                           input pixel_t want = '0);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_load_address <= addr;
    in_load_data <= data;
    in_pixel_row <= row;
    in_pixel_col <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (cmd)
      CMD_LOAD_IMAGE: begin
        image_bytes[addr] = data[7:0];
        image_known[addr] = 1'b1;
      end
      CMD_LOAD_PALETTE: begin
        if (addr < PALETTE_DEPTH) begin
          palette_words[addr[PAL_AW-1:0]] = data;
          palette_known[addr[PAL_AW-1:0]] = 1'b1;
        end
      end
      CMD_READ_PIXEL: expected_pixels.push_back(fixed ? want : predict_pixel(row, col));
      default: ;
    endcase
  endtask

  // Every byte and palette entry the read will use is loaded first if it holds no data yet.
  task automatic read_pixel(input logic [11:0] row, input logic [11:0] col,
                            input bit fixed = 1'b0, input pixel_t want = '0);
    longint a;
    int n, slot;
    pixel_span(row, col, a, n);
    for (int k = 0; k < n; k++) begin
      if (!image_known[a + k]) begin
        send_item(CMD_LOAD_IMAGE, 16'(a + k), 24'($urandom), 12'($urandom), 12'($urandom));
      end
    end
    slot = palette_slot(row, col);
    if (slot >= 0 && slot < PALETTE_DEPTH && !palette_known[slot]) begin
      send_item(CMD_LOAD_PALETTE, 16'(slot), 24'($urandom), 12'($urandom), 12'($urandom));
    end
    send_item(CMD_READ_PIXEL, 16'($urandom), 24'($urandom), row, col, fixed, want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_config(input cfg_t regs);
    start <= 1'b0;
    @(posedge clk);
    while (busy || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_IMAGE_WIDTH, 14'(regs.image_width));
    write_reg(CFG_IMAGE_HEIGHT, regs.image_height);
    write_reg(CFG_BITS_PER_PIXEL, 14'(regs.bits_per_pixel));
    write_reg(CFG_COLORS_USED, 14'(regs.colors_used));
    cfg_we <= 1'b0;
    live_cfg = regs;
  endtask

  always @(posedge clk) begin : check_results
    pixel_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel result arrived with no read outstanding");
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_red !== want.red) begin
          $error("red: expected %02h, got %02h", want.red, out_red);
          fail_count++;
        end
        if (out_green !== want.green) begin
          $error("green: expected %02h, got %02h", want.green, out_green);
          fail_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %02h, got %02h", want.blue, out_blue);
          fail_count++;
        end
        if (out_address_error !== want.address_error) begin
          $error("address_error: expected %0b, got %0b", want.address_error,
                 out_address_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("bmp_pixel_fetch regression: fail");
    $finish;
  end

  initial begin
    cfg_t   regs;
    longint stride, rows_fit;
    int     hm, hmax, wmax, pick;
    logic [5:0] b;
    logic [12:0] w;

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_LOAD_IMAGE;
    in_load_address = '0;
    in_load_data = '0;
    in_pixel_row = '0;
    in_pixel_col = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    fail_count = 0;
    idle_pct = 0;

    // Reset values: one pixel wide, one row stored bottom-up, 8 bits, 256 colors.
    dir_steps.push_back(item_step(CMD_LOAD_PALETTE, 16'd255, 24'hFFFFFF, 12'd0, 12'd0));
    dir_steps.push_back(item_step(CMD_LOAD_PALETTE, 16'hFFFF, 24'h123456, 12'd0, 12'd0));
    dir_steps.push_back(item_step(CMD_LOAD_IMAGE, 16'd0, 24'hFFFFFF, 12'd0, 12'd0));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'd0, 1'b1,
                                  '{8'hFF, 8'hFF, 8'hFF, 1'b0}));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd1, 12'd0, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'hFFF, 12'hFFF, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(item_step(CMD_UNUSED, 16'hFFFF, 24'hFFFFFF, 12'hFFF, 12'hFFF));
    dir_steps.push_back(item_step(CMD_LOAD_IMAGE, 16'hFFFF, 24'h000000, 12'd0, 12'd0));
    dir_steps.push_back(item_step(CMD_LOAD_PALETTE, 16'd0, 24'h000000, 12'd0, 12'd0));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'hFFF));
    dir_steps.push_back(cfg_step(13'd4096, -14'sd4096, 6'd32, 9'd256));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd3, 12'hFFF));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd4, 12'd0, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(cfg_step(13'd1, 14'sd0, 6'd24, 9'd1));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'hFFF, 12'd0));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'hFFF));
    dir_steps.push_back(cfg_step(13'd1, 14'sd1, 6'd16, 9'd256));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'd0, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(cfg_step(13'd4096, 14'sd4096, 6'd1, 9'd0));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'd0, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'hFFF, 12'hFFF));
    dir_steps.push_back(cfg_step(13'd5, -14'sd3, 6'd2, 9'd3));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd2, 12'd4));
    dir_steps.push_back(cfg_step(13'd3, 14'sd2, 6'd4, 9'd1));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd1, 12'd2));
    dir_steps.push_back(cfg_step(13'd7, 14'sd8, 6'd8, 9'd511));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'd6));
    dir_steps.push_back(cfg_step(13'd8191, 14'sd5, 6'd63, 9'd256));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'd0, 12'd0, 1'b1,
                                  PIXEL_FAULT));
    dir_steps.push_back(cfg_step(13'd0, -14'sd4096, 6'd8, 9'd256));
    dir_steps.push_back(item_step(CMD_READ_PIXEL, 16'd0, 24'd0, 12'hFFF, 12'd255));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    live_cfg = cfg_t'{13'd1, 14'sd1, 6'd8, 9'd256};

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        write_config(dir_steps[i].regs);
      end else if (dir_steps[i].cmd == CMD_READ_PIXEL) begin
        read_pixel(dir_steps[i].row, dir_steps[i].col, dir_steps[i].fixed, dir_steps[i].want);
      end else begin
        send_item(dir_steps[i].cmd, dir_steps[i].addr, dir_steps[i].data, dir_steps[i].row,
                  dir_steps[i].col);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // The result port cannot be stalled, so the phases vary only how often the input side idles.
      case (ph % 4)
        1: idle_pct = 73;
        3: idle_pct = 9;
        default: idle_pct = 0;
      endcase
      case (ph)
        0: regs = cfg_t'{13'd4096, 14'sd4, 6'd32, 9'd256};
        1: regs = cfg_t'{13'd1, -14'sd4096, 6'd1, 9'd0};
        2: regs = cfg_t'{13'd4096, 14'sd16, 6'd8, 9'd1};
        3: regs = cfg_t'{13'd4096, -14'sd32, 6'd4, 9'd511};
        default: begin
          case ($urandom_range(5))
            0: b = 6'd1;
            1: b = 6'd2;
            2: b = 6'd4;
            3: b = 6'd8;
            4: b = 6'd24;
            default: b = 6'd32;
          endcase
          if ($urandom_range(9) == 0) b = 6'($urandom_range(0, 63));
          w = ($urandom_range(4) == 0) ? 13'($urandom_range(0, 8191))
                                       : 13'($urandom_range(1, 64));
          stride = ((longint'(w) * b + 31) >> 5) << 2;
          rows_fit = (stride == 0) ? 4096 : 65536 / stride;
          if (rows_fit > 4096) rows_fit = 4096;
          hm = $urandom_range(0, int'(rows_fit));
          regs.image_width = w;
          regs.image_height = $urandom_range(1) ? 14'(hm) : 14'(-hm);
          regs.bits_per_pixel = b;
          case ($urandom_range(4))
            0: regs.colors_used = 9'd0;
            1: regs.colors_used = 9'd1;
            2: regs.colors_used = 9'd256;
            3: regs.colors_used = 9'($urandom_range(0, 511));
            default: regs.colors_used = 9'($urandom_range(1, 256));
          endcase
        end
      endcase
      write_config(regs);

      hmax = live_cfg.image_height;
      if (hmax < 0) hmax = -hmax;
      if (hmax > 4095) hmax = 4095;
      wmax = live_cfg.image_width;
      if (wmax > 4095) wmax = 4095;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          read_pixel(($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(0, hmax)),
                     ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(0, wmax)));
        end else if (pick < 82) begin
          send_item(CMD_LOAD_IMAGE, 16'($urandom), 24'($urandom), 12'($urandom),
                    12'($urandom));
        end else if (pick < 95) begin
          send_item(CMD_LOAD_PALETTE,
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255)),
                    24'($urandom), 12'($urandom), 12'($urandom));
        end else begin
          send_item(CMD_UNUSED, 16'($urandom), 24'($urandom), 12'($urandom), 12'($urandom));
        end
      end
    end

    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bmp_pixel_fetch regression: pass");
    end else begin
      $display("bmp_pixel_fetch regression: fail");
    end
    $finish;
  end

endmodule
